// ===== rtl/pkst_pkg.sv =====
package pkst_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } pkst_state_t;

  // result codes
  localparam logic [2:0] OUT_PROGRESSED = 3'd0;
  localparam logic [2:0] OUT_COMPLETED  = 3'd1;
  localparam logic [2:0] OUT_WRONG      = 3'd2;
  localparam logic [2:0] OUT_UNKNOWN    = 3'd3;
  localparam logic [2:0] OUT_FULL       = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_KNOCK_FIRST  = 2'd0;
  localparam logic [1:0] REG_KNOCK_SECOND = 2'd1;
  localparam logic [1:0] REG_KNOCK_THIRD  = 2'd2;
  localparam logic [1:0] REG_TIMEOUT      = 2'd3;

  // configuration reset values
  localparam logic [15:0] RST_KNOCK_FIRST  = 16'd1234;
  localparam logic [15:0] RST_KNOCK_SECOND = 16'd5678;
  localparam logic [15:0] RST_KNOCK_THIRD  = 16'd9101;
  localparam logic [15:0] RST_TIMEOUT      = 16'd10;

  // knock progress values
  localparam logic [1:0] STAGE_FIRST  = 2'd0;
  localparam logic [1:0] STAGE_SECOND = 2'd1;
  localparam logic [1:0] STAGE_THIRD  = 2'd2;

  // one session table entry
  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  progress;
    logic [31:0] last_time;
  } pkst_entry_t;

endpackage

// ===== rtl/pkst_table.sv =====
module pkst_table
  import pkst_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [IW-1:0] wr_idx,
  input  pkst_entry_t wr_entry,
  input  logic        rd_en,
  input  logic [IW-1:0] rd_idx,
  output pkst_entry_t rd_entry
);

  pkst_entry_t mem [DEPTH];
  pkst_entry_t rd_entry_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= mem[rd_idx];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

// ===== rtl/port_knock_session_tracker.sv =====
// Port-knock session tracker: each input beat is one knock (source address,
// destination port, time in seconds) and yields exactly one result beat with
// the address, a grant flag and an outcome code. Sessions live in a table of
// NUM_SESSIONS entries held in a memory with one read and one write port; a
// knock is handled by walking that memory one entry per cycle through one
// shared address comparator, stopping at the first matching valid entry, then
// a decision state that judges the timeout and the expected port and updates
// or frees the entry. The decision state waits while the output register
// still holds an untaken result. in_tready is low while a knock is being
// handled and rises in the cycle after the decision, so a new knock is
// accepted only once the previous one is decided; a finished result waits in
// the output register while the next knock is accepted. Entry valid flags
// are cleared by reset, so no clearing pass is needed after reset.
module port_knock_session_tracker
  import pkst_pkg::*;
#(
  parameter int NUM_SESSIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // knock input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // src_addr[31:0], dst_port[47:32], now_seconds[79:48]
  // result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_addr[31:0]
  output logic [3:0]  out_tuser,  // granted[0], outcome[3:1]
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wr_data
);

  localparam int IW = (NUM_SESSIONS > 1) ? $clog2(NUM_SESSIONS) : 1;
  localparam int CW = $clog2(NUM_SESSIONS + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(NUM_SESSIONS);

  // sequencer
  pkst_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // knock being handled
  logic [31:0] addr_r, addr_nxt;
  logic [15:0] port_r, port_nxt;
  logic [31:0] now_r, now_nxt;

  // scan results
  logic          hit_r, hit_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic [1:0]    hit_prog_r, hit_prog_nxt;
  logic [31:0]   hit_time_r, hit_time_nxt;
  logic          free_found_r, free_found_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;

  // entry valid flags
  logic [NUM_SESSIONS-1:0] valid_r, valid_nxt;

  // configuration
  logic [15:0] knock_first_r, knock_first_nxt;
  logic [15:0] knock_second_r, knock_second_nxt;
  logic [15:0] knock_third_r, knock_third_nxt;
  logic [15:0] timeout_r, timeout_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_addr_r, out_addr_nxt;
  logic        out_granted_r, out_granted_nxt;
  logic [2:0]  out_outcome_r, out_outcome_nxt;

  // control
  logic          in_fire;
  logic          out_free;
  logic          exec_fire;
  logic          rd_en;
  logic [IW-1:0] rd_idx;
  logic          cmp_live;
  logic [IW-1:0] cmp_idx;
  logic          cmp_hit;
  logic          cmp_free;
  pkst_entry_t   rd_entry;

  // decision
  logic [31:0] gap;
  logic        expired;
  logic [1:0]  stage;
  logic        has_want;
  logic [15:0] want;
  logic        port_ok;
  logic [2:0]  exec_outcome;
  logic        exec_wr;
  logic        exec_set;
  logic        exec_clr;
  logic [IW-1:0] exec_idx;
  pkst_entry_t exec_entry;

  // session memory
  pkst_table #(
    .DEPTH (NUM_SESSIONS),
    .IW    (IW)
  ) u_table (
    .clk      (clk),
    .wr_en    (exec_fire && exec_wr),
    .wr_idx   (exec_idx),
    .wr_entry (exec_entry),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry)
  );

  // handshakes
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // shared address comparator on the registered read data
  assign cmp_idx  = IW'(cnt_r - CW'(1));
  assign cmp_hit  = cmp_live && valid_r[cmp_idx] && (rd_entry.addr == addr_r);
  assign cmp_free = cmp_live && !valid_r[cmp_idx];
  assign rd_idx   = cnt_r[IW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cmp_hit || (cnt_r == LAST_CNT)) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    cmp_live  = 1'b0;
    exec_fire = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_SCAN: begin
        rd_en    = (cnt_r != LAST_CNT);
        cmp_live = (cnt_r != '0);
      end
      ST_EXEC: begin
        exec_fire = out_free;
      end
      default: ;
    endcase
  end

  // timeout check and expected port
  always_comb begin
    gap      = now_r - hit_time_r;
    expired  = gap > {16'h0000, timeout_r};
    stage    = expired ? STAGE_FIRST : hit_prog_r;
    has_want = 1'b1;
    want     = knock_first_r;
    case (stage)
      STAGE_FIRST:  want = knock_first_r;
      STAGE_SECOND: want = knock_second_r;
      STAGE_THIRD:  want = knock_third_r;
      default:      has_want = 1'b0;
    endcase
    port_ok = has_want && (want == port_r);
  end

  // knock decision
  always_comb begin
    exec_outcome         = OUT_UNKNOWN;
    exec_wr              = 1'b0;
    exec_set             = 1'b0;
    exec_clr             = 1'b0;
    exec_idx             = hit_r ? hit_idx_r : free_idx_r;
    exec_entry.addr      = addr_r;
    exec_entry.progress  = stage + 2'd1;
    exec_entry.last_time = now_r;
    if (hit_r) begin
      if (port_ok) begin
        if (stage == STAGE_THIRD) begin
          exec_outcome = OUT_COMPLETED;
          exec_clr     = 1'b1;
        end else begin
          exec_outcome = OUT_PROGRESSED;
          exec_wr      = 1'b1;
        end
      end else begin
        exec_outcome = OUT_WRONG;
        exec_clr     = 1'b1;
      end
    end else if (port_r == knock_first_r) begin
      exec_entry.progress = 2'd1;
      if (free_found_r) begin
        exec_outcome = OUT_PROGRESSED;
        exec_wr      = 1'b1;
        exec_set     = 1'b1;
      end else begin
        exec_outcome = OUT_FULL;
      end
    end
  end

  // datapath next values
  always_comb begin
    cnt_nxt          = cnt_r;
    addr_nxt         = addr_r;
    port_nxt         = port_r;
    now_nxt          = now_r;
    hit_nxt          = hit_r;
    hit_idx_nxt      = hit_idx_r;
    hit_prog_nxt     = hit_prog_r;
    hit_time_nxt     = hit_time_r;
    free_found_nxt   = free_found_r;
    free_idx_nxt     = free_idx_r;
    valid_nxt        = valid_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_addr_nxt     = out_addr_r;
    out_granted_nxt  = out_granted_r;
    out_outcome_nxt  = out_outcome_r;
    knock_first_nxt  = knock_first_r;
    knock_second_nxt = knock_second_r;
    knock_third_nxt  = knock_third_r;
    timeout_nxt      = timeout_r;

    // take a knock
    if (in_fire) begin
      addr_nxt       = in_tdata[31:0];
      port_nxt       = in_tdata[47:32];
      now_nxt        = in_tdata[79:48];
      cnt_nxt        = '0;
      hit_nxt        = 1'b0;
      free_found_nxt = 1'b0;
    end

    // walk the table
    if (state_r == ST_SCAN) begin
      if (cnt_r != LAST_CNT) cnt_nxt = cnt_r + CW'(1);
      if (cmp_hit) begin
        hit_nxt      = 1'b1;
        hit_idx_nxt  = cmp_idx;
        hit_prog_nxt = rd_entry.progress;
        hit_time_nxt = rd_entry.last_time;
      end
      if (cmp_free && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = cmp_idx;
      end
    end

    // commit the decision
    if (exec_fire) begin
      if (exec_set) valid_nxt[free_idx_r] = 1'b1;
      if (exec_clr) valid_nxt[hit_idx_r]  = 1'b0;
      out_valid_nxt   = 1'b1;
      out_addr_nxt    = addr_r;
      out_granted_nxt = (exec_outcome == OUT_COMPLETED);
      out_outcome_nxt = exec_outcome;
    end

    // register writes
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_KNOCK_FIRST:  knock_first_nxt  = cfg_wr_data;
        REG_KNOCK_SECOND: knock_second_nxt = cfg_wr_data;
        REG_KNOCK_THIRD:  knock_third_nxt  = cfg_wr_data;
        REG_TIMEOUT:      timeout_nxt      = cfg_wr_data;
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      valid_r        <= '0;
      out_valid_r    <= 1'b0;
      knock_first_r  <= RST_KNOCK_FIRST;
      knock_second_r <= RST_KNOCK_SECOND;
      knock_third_r  <= RST_KNOCK_THIRD;
      timeout_r      <= RST_TIMEOUT;
    end else begin
      state_r        <= state_nxt;
      valid_r        <= valid_nxt;
      out_valid_r    <= out_valid_nxt;
      knock_first_r  <= knock_first_nxt;
      knock_second_r <= knock_second_nxt;
      knock_third_r  <= knock_third_nxt;
      timeout_r      <= timeout_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    addr_r        <= addr_nxt;
    port_r        <= port_nxt;
    now_r         <= now_nxt;
    hit_r         <= hit_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_prog_r    <= hit_prog_nxt;
    hit_time_r    <= hit_time_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    out_addr_r    <= out_addr_nxt;
    out_granted_r <= out_granted_nxt;
    out_outcome_r <= out_outcome_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = {out_outcome_r, out_granted_r};

`ifndef SYNTHESIS
  // grant flag agrees with the outcome code
  a_grant_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (out_tuser[3:1] == OUT_COMPLETED)))
    else $error("grant flag disagrees with outcome");

  // a committed decision always reaches the output register
  a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_valid_r)
    else $error("decision lost before the output register");

  // the session table only changes in the decision cycle
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_EXEC) |=> $stable(valid_r))
    else $error("valid flags changed outside the decision cycle");

  // a found session is still valid when judged
  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && hit_r) |-> valid_r[hit_idx_r])
    else $error("matched session not valid");

  // at most one session opens per knock
  a_one_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> ($countones(valid_r) <= $countones($past(valid_r)) + 1))
    else $error("more than one session opened");
`endif

endmodule

// ===== tb/port_knock_session_tracker_test.sv =====
`timescale 1ns / 100ps

module port_knock_session_tracker_test;
  import pkst_pkg::*;

  localparam int SESSIONS   = 16;
  localparam int POOL_SIZE  = 24;
  localparam int CYCLE_CAP  = 500000;
  localparam int TAIL_WAIT  = 25;

  // expected result of one knock
  typedef struct {
    logic        granted;
    logic [31:0] addr;
    logic [2:0]  outcome;
  } knock_verdict_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata    = '0;  // src_addr[31:0], dst_port[47:32], now_seconds[79:48]
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;         // result_addr[31:0]
  logic [3:0]  out_tuser;         // granted[0], outcome[3:1]
  logic        cfg_wr_en   = 1'b0;
  logic [1:0]  cfg_index   = '0;
  logic [15:0] cfg_wr_data = '0;

  // predictor copy of the session table and registers
  logic        sess_live  [SESSIONS];
  logic [31:0] sess_addr  [SESSIONS];
  logic [1:0]  sess_stage [SESSIONS];
  logic [31:0] sess_stamp [SESSIONS];
  logic [15:0] knock_port [3];
  logic [15:0] knock_timeout;

  knock_verdict_t pending_verdicts[$];
  logic [31:0]    peer_pool [POOL_SIZE];
  logic [31:0]    epoch = 32'd1000;
  bit             idle_on = 1'b1;
  int             mismatches = 0;
  int             cycles = 0;
  int             stall_left = 0;
  int             stall_draw;

  port_knock_session_tracker #(.NUM_SESSIONS(SESSIONS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // predictor: judge one accepted knock and queue its verdict
  function automatic void judge_knock(input logic [31:0] addr, input logic [15:0] port,
                                      input logic [31:0] now);
    int             hit;
    logic [1:0]     stage;
    logic [31:0]    gap;
    knock_verdict_t v;
    hit = -1;
    v.outcome = OUT_UNKNOWN;
    for (int k = 0; k < SESSIONS; k++)
      if (hit < 0 && sess_live[k] && sess_addr[k] == addr) hit = k;
    if (hit >= 0) begin
      stage = sess_stage[hit];
      gap = now - sess_stamp[hit];
      if (gap > {16'd0, knock_timeout}) stage = STAGE_FIRST;
      if (stage <= STAGE_THIRD && port == knock_port[stage]) begin
        if (stage == STAGE_THIRD) begin
          sess_live[hit] = 1'b0;
          v.outcome = OUT_COMPLETED;
        end else begin
          sess_stage[hit] = stage + 2'd1;
          sess_stamp[hit] = now;
          v.outcome = OUT_PROGRESSED;
        end
      end else begin
        sess_live[hit] = 1'b0;
        v.outcome = OUT_WRONG;
      end
    end else if (port == knock_port[STAGE_FIRST]) begin
      v.outcome = OUT_FULL;
      for (int k = 0; k < SESSIONS; k++)
        if (v.outcome == OUT_FULL && !sess_live[k]) begin
          sess_live[k]  = 1'b1;
          sess_addr[k]  = addr;
          sess_stage[k] = STAGE_SECOND;
          sess_stamp[k] = now;
          v.outcome = OUT_PROGRESSED;
        end
    end
    v.granted = (v.outcome == OUT_COMPLETED);
    v.addr = addr;
    pending_verdicts.push_back(v);
  endfunction

  // port that would move this address on at this time
  function automatic logic [15:0] next_port(input logic [31:0] addr, input logic [31:0] now);
    logic [15:0] port;
    logic [31:0] gap;
    port = knock_port[STAGE_FIRST];
    for (int k = SESSIONS - 1; k >= 0; k--)
      if (sess_live[k] && sess_addr[k] == addr) begin
        gap = now - sess_stamp[k];
        port = (gap > {16'd0, knock_timeout} || sess_stage[k] > STAGE_THIRD) ?
               knock_port[STAGE_FIRST] : knock_port[sess_stage[k]];
      end
    return port;
  endfunction

  task automatic check_verdict();
    knock_verdict_t want;
    if (pending_verdicts.size() == 0) begin
      report_mismatch($sformatf("unexpected result for %h", out_tdata));
      return;
    end
    want = pending_verdicts.pop_front();
    if (out_tdata !== want.addr)
      report_mismatch($sformatf("addr %h, want %h", out_tdata, want.addr));
    if (out_tuser[0] !== want.granted)
      report_mismatch($sformatf("granted %b, want %b for %h", out_tuser[0], want.granted,
                                want.addr));
    if (out_tuser[3:1] !== want.outcome)
      report_mismatch($sformatf("outcome %0d, want %0d for %h", out_tuser[3:1], want.outcome,
                                want.addr));
  endtask

  // result side: random stalls after each beat while idle_on is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (out_tvalid && out_tready) begin
      check_verdict();
      stall_draw = idle_on ? $urandom_range(0, 5) : 0;
      out_tready <= (stall_draw == 0);
      stall_left <= stall_draw;
    end else if (!out_tready) begin
      if (stall_left <= 1) out_tready <= 1'b1;
      stall_left <= stall_left - 1;
    end
  end

  // one knock beat; valid stays high when the next beat follows at once
  task automatic send_knock(input logic [31:0] addr, input logic [15:0] port,
                            input logic [31:0] now);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {now, port, addr};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    judge_knock(addr, port, now);
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  task automatic program_knock(input logic [15:0] p1, input logic [15:0] p2,
                               input logic [15:0] p3, input logic [15:0] tmo);
    logic [15:0] vals [4];
    logic [1:0]  regs [4];
    vals = '{p1, p2, p3, tmo};
    regs = '{REG_KNOCK_FIRST, REG_KNOCK_SECOND, REG_KNOCK_THIRD, REG_TIMEOUT};
    for (int r = 0; r < 4; r++) begin
      cfg_wr_en   <= 1'b1;
      cfg_index   <= regs[r];
      cfg_wr_data <= vals[r];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    knock_port[STAGE_FIRST]  = p1;
    knock_port[STAGE_SECOND] = p2;
    knock_port[STAGE_THIRD]  = p3;
    knock_timeout = tmo;
  endtask

  // full sequence, last gap exactly on the timeout
  task automatic test_grant_sequence();
    send_knock(32'h0A00_0001, 16'd1234, 32'd100);
    send_knock(32'h0A00_0001, 16'd5678, 32'd105);
    send_knock(32'h0A00_0001, 16'd9101, 32'd115);
  endtask

  task automatic test_wrong_port();
    send_knock(32'h0A00_0002, 16'd5678, 32'd200);
    send_knock(32'h0A00_0002, 16'd1234, 32'd200);
    send_knock(32'h0A00_0002, 16'd9101, 32'd201);
    send_knock(32'h0A00_0002, 16'd5678, 32'd202);
  endtask

  // expired session judged against the first port, both ways
  task automatic test_timeout_restart();
    send_knock(32'h0A00_0003, 16'd1234, 32'd300);
    send_knock(32'h0A00_0003, 16'd5678, 32'd311);
    send_knock(32'h0A00_0003, 16'd1234, 32'd400);
    send_knock(32'h0A00_0003, 16'd1234, 32'd420);
    send_knock(32'h0A00_0003, 16'd5678, 32'd425);
    send_knock(32'h0A00_0003, 16'd9101, 32'd425);
  endtask

  // time wrap and field extremes
  task automatic test_field_extremes();
    send_knock(32'hFFFF_FFFF, 16'd1234, 32'hFFFF_FFFE);
    send_knock(32'hFFFF_FFFF, 16'd5678, 32'h0000_0003);
    send_knock(32'hFFFF_FFFF, 16'd9101, 32'hFFFF_FFFF);
    send_knock(32'h0000_0000, 16'h0000, 32'h0000_0000);
    send_knock(32'h0000_0000, 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  // extreme port values with a zero timeout
  task automatic test_extreme_ports();
    send_knock(32'h0B00_0001, 16'h0000, 32'd500);
    send_knock(32'h0B00_0001, 16'hFFFF, 32'd500);
    send_knock(32'h0B00_0001, 16'h0000, 32'd500);
    send_knock(32'h0B00_0002, 16'h0000, 32'd600);
    send_knock(32'h0B00_0002, 16'hFFFF, 32'd601);
  endtask

  // all ports equal, widest timeout
  task automatic test_equal_ports();
    send_knock(32'h0C00_0001, 16'd7, 32'd700);
    send_knock(32'h0C00_0001, 16'd7, 32'd700);
    send_knock(32'h0C00_0001, 16'd7, 32'd700);
    send_knock(32'h0C00_0002, 16'd7, 32'd1000);
    send_knock(32'h0C00_0002, 16'd7, 32'd66535);
    send_knock(32'h0C00_0002, 16'd7, 32'd132071);
    send_knock(32'h0C00_0002, 16'd7, 32'd132071);
    send_knock(32'h0C00_0002, 16'd7, 32'd132071);
  endtask

  // fill every entry, overflow once, then clear the table
  task automatic test_table_full();
    logic [31:0] crowd [SESSIONS + 1];
    for (int k = 0; k <= SESSIONS; k++) crowd[k] = $urandom;
    for (int k = 0; k <= SESSIONS; k++)
      send_knock(crowd[k], knock_port[STAGE_FIRST], epoch);
    send_knock(crowd[SESSIONS], knock_port[STAGE_SECOND], epoch);
    for (int k = 0; k < SESSIONS; k++)
      send_knock(crowd[k], ~knock_port[STAGE_SECOND], epoch + 1);
  endtask

  // mostly well-formed sessions from a small peer pool, some noise
  task automatic test_random_sessions(input int count);
    logic [31:0] addr;
    logic [15:0] port;
    bit          fresh;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) epoch += $urandom_range(0, 3);
      else if (pick < 85) epoch += {16'd0, knock_timeout} + $urandom_range(0, 1);
      else if (pick < 95) epoch += $urandom_range(0, 70000);
      else epoch = $urandom;
      fresh = ($urandom_range(0, 9) == 0);
      addr = fresh ? $urandom : peer_pool[$urandom_range(0, POOL_SIZE - 1)];
      pick = $urandom_range(0, 99);
      if (fresh || pick >= 90) port = 16'($urandom_range(0, 65535));
      else if (pick < 80) port = next_port(addr, epoch);
      else port = knock_port[$urandom_range(0, 2)];
      send_knock(addr, port, epoch);
    end
  endtask

  initial begin
    for (int k = 0; k < SESSIONS; k++) begin
      sess_live[k]  = 1'b0;
      sess_addr[k]  = '0;
      sess_stage[k] = STAGE_FIRST;
      sess_stamp[k] = '0;
    end
    knock_port[STAGE_FIRST]  = RST_KNOCK_FIRST;
    knock_port[STAGE_SECOND] = RST_KNOCK_SECOND;
    knock_port[STAGE_THIRD]  = RST_KNOCK_THIRD;
    knock_timeout = RST_TIMEOUT;
    for (int k = 0; k < POOL_SIZE; k++) peer_pool[k] = $urandom;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, first at the reset values of the registers, then at programmed ones
    test_grant_sequence();
    test_wrong_port();
    test_timeout_restart();
    test_field_extremes();
    wait_drained();
    program_knock(16'h0000, 16'hFFFF, 16'h0000, 16'd0);
    test_extreme_ports();
    wait_drained();
    program_knock(16'd7, 16'd7, 16'd7, 16'hFFFF);
    test_equal_ports();
    wait_drained();
    program_knock(RST_KNOCK_FIRST, RST_KNOCK_SECOND, RST_KNOCK_THIRD, RST_TIMEOUT);
    test_table_full();

    // random phases over several register settings
    test_random_sessions(400);
    wait_drained();
    idle_on = 1'b0;
    program_knock(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(0, 20)));
    test_random_sessions(350);
    wait_drained();
    idle_on = 1'b1;
    program_knock(16'($urandom), 16'($urandom), 16'($urandom), 16'hFFFF);
    test_random_sessions(300);
    wait_drained();
    program_knock(16'hFFFF, 16'h0000, 16'hFFFF, 16'd0);
    test_random_sessions(300);
    wait_drained();
    program_knock(16'd80, 16'd80, 16'd443, 16'd5);
    test_random_sessions(300);
    wait_drained();
    program_knock(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    test_random_sessions(200);

    wait_drained();
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
